/* rtl/pwf_pkg.sv */
// Shared constants and controller/datapath interface types for the palindrome word filter.
package pwf_pkg;

   localparam int MAX_WORD = 32;
   localparam int ADDR_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int LEN_W    = $clog2(MAX_WORD + 1);

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   typedef struct packed {
      logic wr;
      logic set_ovf;
      logic clr_word;
      logic cmp_init;
      logic cmp_step;
      logic emit_init;
      logic emit_step;
      logic load_char;
      logic load_space;
   } pwf_cmd_type;

   typedef struct packed {
      logic is_delim;
      logic full;
      logic ovf;
      logic cmp_more;
      logic cmp_equal;
      logic emit_more;
      logic out_free;
   } pwf_status_type;

endpackage

/* rtl/pwf_ctrl.sv */
// Controller state machine: word collection, mirror check walk and emission sequencing.
module pwf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pwf_pkg::pwf_status_type status,
   output pwf_pkg::pwf_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_CMP_RD     = 6'b000010,
      ST_CMP_CHK    = 6'b000100,
      ST_EMIT_RD    = 6'b001000,
      ST_EMIT_WAIT  = 6'b010000,
      ST_EMIT_SPACE = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.is_delim) begin
                  if (status.ovf) begin
                     cmd.clr_word = 1'b1;
                  end else begin
                     cmd.cmp_init = 1'b1;
                     state_in     = ST_CMP_RD;
                  end
               end else if (status.full) begin
                  cmd.set_ovf = 1'b1;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_CMP_RD: begin
            if (status.cmp_more) begin
               cmd.cmp_step = 1'b1;
               state_in     = ST_CMP_CHK;
            end else begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_CMP_CHK: begin
            if (status.cmp_equal) begin
               state_in = ST_CMP_RD;
            end else begin
               cmd.clr_word = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            if (status.emit_more) begin
               cmd.emit_step = 1'b1;
               state_in      = ST_EMIT_WAIT;
            end else begin
               state_in = ST_EMIT_SPACE;
            end
         end
         ST_EMIT_WAIT: begin
            if (status.out_free) begin
               cmd.load_char = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_EMIT_SPACE: begin
            if (status.out_free) begin
               cmd.load_space = 1'b1;
               cmd.clr_word   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/pwf_dp.sv */
// Datapath: word buffer memory, length and overflow state, walk pointers and output register.
module pwf_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_in_char,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_char,
   output logic                     rsp_last,
   input  pwf_pkg::pwf_cmd_type     cmd,
   output pwf_pkg::pwf_status_type  status
);

   logic [7:0]               mem [pwf_pkg::MAX_WORD];
   logic [pwf_pkg::LEN_W-1:0] len_ff;
   logic [pwf_pkg::LEN_W-1:0] len_in;
   logic                      ovf_ff;
   logic                      ovf_in;
   logic [pwf_pkg::LEN_W-1:0] lo_ff;
   logic [pwf_pkg::LEN_W-1:0] hi_ff;
   logic [pwf_pkg::LEN_W-1:0] hi_m1;
   logic [7:0]                rd_a_ff;
   logic [7:0]                rd_b_ff;
   logic                      out_valid_ff;
   logic [7:0]                out_char_ff;
   logic                      out_last_ff;
   logic                      out_free;

   assign hi_m1    = hi_ff - pwf_pkg::LEN_W'(1);
   assign out_free = !out_valid_ff || !rsp_stall;

   assign status.is_delim  = (req_in_char == pwf_pkg::CH_SPACE) ||
                             (req_in_char == pwf_pkg::CH_NEWLINE);
   assign status.full      = (len_ff == pwf_pkg::LEN_W'(pwf_pkg::MAX_WORD));
   assign status.ovf       = ovf_ff;
   assign status.cmp_more  = ((lo_ff + pwf_pkg::LEN_W'(1)) < hi_ff);
   assign status.cmp_equal = (rd_a_ff == rd_b_ff);
   assign status.emit_more = (lo_ff < len_ff);
   assign status.out_free  = out_free;

   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (cmd.clr_word) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.wr) begin
         len_in = len_ff + pwf_pkg::LEN_W'(1);
      end else if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[len_ff[pwf_pkg::ADDR_W-1:0]] <= req_in_char;
      end
      if (cmd.cmp_step || cmd.emit_step) begin
         rd_a_ff <= mem[lo_ff[pwf_pkg::ADDR_W-1:0]];
         rd_b_ff <= mem[hi_m1[pwf_pkg::ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp_init) begin
         lo_ff <= '0;
         hi_ff <= len_ff;
      end else if (cmd.emit_init) begin
         lo_ff <= '0;
      end else if (cmd.cmp_step) begin
         lo_ff <= lo_ff + pwf_pkg::LEN_W'(1);
         hi_ff <= hi_m1;
      end else if (cmd.emit_step) begin
         lo_ff <= lo_ff + pwf_pkg::LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_char || cmd.load_space) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         out_char_ff <= rd_a_ff;
         out_last_ff <= 1'b0;
      end else if (cmd.load_space) begin
         out_char_ff <= pwf_pkg::CH_SPACE;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = out_last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= pwf_pkg::LEN_W'(pwf_pkg::MAX_WORD))
      else $error("word length beyond buffer depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == pwf_pkg::LEN_W'(pwf_pkg::MAX_WORD)))
      else $error("overflow flag set on a word that is not full");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_char || cmd.load_space) |-> out_free)
      else $error("output register loaded while holding a stalled item");

   a_no_write_walk: assert property (@(posedge clock) disable iff (reset)
      (cmd.cmp_step || cmd.emit_step) |-> !cmd.wr)
      else $error("buffer written during check or emission walk");

endmodule

/* rtl/palindrome_word_filter.sv */
// Palindrome word filter: buffers a byte stream into words and emits the mirror-symmetric ones.
// Ordinary byte, or a delimiter after an overflowed word: taken back to back.
// Delimiter ending a word of L bytes: a check walk over mirrored byte pairs, each a two-port
// buffer read, registered, then compare; a mismatch drops the word. A mirrored word is then
// emitted byte by byte plus a trailing space, waiting while rsp_stall holds the output.
// Synchronous active-high reset empties the word and output register; buffer contents unaffected.
module palindrome_word_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last
);

   pwf_pkg::pwf_cmd_type    cmd;
   pwf_pkg::pwf_status_type status;

   pwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pwf_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_in_char  (req_in_char),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

/* tb/palindrome_word_filter_tb.sv */
// Self-checking testbench for the palindrome word filter: byte stream in, palindromes out.
module palindrome_word_filter_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } emitted_byte_type;

   typedef enum logic [1:0] {SHAPE_MIRROR, SHAPE_NEAR, SHAPE_RANDOM} word_shape_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last;

   logic [7:0]       word_buf [$];
   int               word_len   = 0;
   bit               word_ovf   = 1'b0;
   emitted_byte_type emitted_q [$];

   int fail_count  = 0;
   int cycle_count = 0;
   bit idle_on     = 1'b1;
   int hold_token  = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int burst_left  = 0;

   palindrome_word_filter u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_char  (req_in_char),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // buffer the byte, or close the word and queue the bytes it emits
   task automatic filter_char(input logic [7:0] ch);
      int  lo;
      int  hi;
      bit  mirror;
      emitted_byte_type e;
      if (ch != pwf_pkg::CH_SPACE && ch != pwf_pkg::CH_NEWLINE) begin
         if (word_len < pwf_pkg::MAX_WORD) begin
            word_buf.push_back(ch);
            word_len++;
         end else begin
            word_ovf = 1'b1;
         end
      end else begin
         mirror = 1'b1;
         lo = 0;
         hi = word_len - 1;
         while (lo < hi) begin
            if (word_buf[lo] != word_buf[hi]) mirror = 1'b0;
            lo++;
            hi--;
         end
         if (!word_ovf && mirror) begin
            for (int k = 0; k < word_len; k++) begin
               e.ch   = word_buf[k];
               e.last = 1'b0;
               emitted_q.push_back(e);
            end
            e.ch   = pwf_pkg::CH_SPACE;
            e.last = 1'b1;
            emitted_q.push_back(e);
         end
         word_buf.delete();
         word_len = 0;
         word_ovf = 1'b0;
      end
   endtask

   always @(posedge clock) begin : check_output
      emitted_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (emitted_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, got char %h last %b",
                     $time, rsp_out_char, rsp_last);
            fail_count++;
         end else begin
            want = emitted_q.pop_front();
            if (rsp_out_char !== want.ch) begin
               $display("%0t: out_char expected %h, got %h", $time, want.ch, rsp_out_char);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %b, got %b", $time, want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stall bursts, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         burst_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_char(input logic [7:0] ch);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= ch;
      do @(posedge clock); while (req_stall);
      filter_char(ch);
   endtask

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == pwf_pkg::CH_SPACE || c == pwf_pkg::CH_NEWLINE);
      return c;
   endfunction

   task automatic send_word(input int len, input word_shape_type shape);
      logic [7:0] text [$];
      int         pos;
      logic [7:0] alt;
      for (int i = 0; i < len; i++) text.push_back(rand_letter());
      if (shape != SHAPE_RANDOM) begin
         for (int i = 0; i < len / 2; i++) text[len-1-i] = text[i];
      end
      if (shape == SHAPE_NEAR && len > 1) begin
         pos = $urandom_range(0, len / 2 - 1);
         do alt = rand_letter(); while (alt == text[pos]);
         text[pos] = alt;
      end
      for (int i = 0; i < len; i++) send_char(text[i]);
      send_char($urandom_range(0, 1) ? pwf_pkg::CH_SPACE : pwf_pkg::CH_NEWLINE);
   endtask

   task automatic test_directed();
      logic [7:0] seq [$];
      seq = '{pwf_pkg::CH_SPACE, pwf_pkg::CH_NEWLINE,
              8'h00, pwf_pkg::CH_SPACE,
              8'hFF, 8'h80, 8'hFF, pwf_pkg::CH_NEWLINE,
              8'h7F, 8'h7F, pwf_pkg::CH_SPACE,
              8'h01, 8'h02, pwf_pkg::CH_SPACE,
              8'h61, 8'h62, 8'h63, 8'h62, 8'h60, pwf_pkg::CH_NEWLINE,
              8'h21, 8'h0B, 8'h21, pwf_pkg::CH_SPACE};
      foreach (seq[i]) send_char(seq[i]);
   endtask

   task automatic test_word_limits();
      send_word(pwf_pkg::MAX_WORD, SHAPE_MIRROR);
      send_word(pwf_pkg::MAX_WORD, SHAPE_NEAR);
      send_word(pwf_pkg::MAX_WORD + 1, SHAPE_MIRROR);
      send_char(pwf_pkg::CH_SPACE);
      send_word(pwf_pkg::MAX_WORD - 1, SHAPE_MIRROR);
   endtask

   task automatic test_random_text();
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < 70) begin
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            send_char(8'($urandom_range(0, 255)));
            sent++;
         end else begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(9, pwf_pkg::MAX_WORD + 2);
            else len = $urandom_range(0, 8);
            if (pick < 12) send_word(len, SHAPE_MIRROR);
            else if (pick < 16) send_word(len, SHAPE_NEAR);
            else send_word(len, SHAPE_RANDOM);
            sent += len + 1;
         end
      end
   endtask

   task automatic test_output_hold();
      @(posedge clock);
      hold_token++;
      for (int i = 0; i < 6; i++) send_word($urandom_range(4, 10), SHAPE_MIRROR);
   endtask

   task automatic test_steady_stream();
      int sent;
      int len;
      idle_on = 1'b0;
      sent = 0;
      while (sent < 35) begin
         len = $urandom_range(0, 6);
         send_word(len, $urandom_range(0, 2) == 0 ? SHAPE_NEAR : SHAPE_MIRROR);
         sent += len + 1;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_word_limits();
      test_random_text();
      test_output_hold();
      test_steady_stream();
      @(negedge clock);
      req_valid <= 1'b0;
      while (emitted_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (emitted_q.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, emitted_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/pwf_pkg.sv
rtl/pwf_ctrl.sv
rtl/pwf_dp.sv
rtl/palindrome_word_filter.sv
tb/palindrome_word_filter_tb.sv
